// ===== hdl/idiv64_pkg.sv =====
// Package for the 64-bit integer divider: request codes, widths and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package idiv64_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned REM_W  = 32;
    localparam int unsigned TYPE_W = 2;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    // Request codes. The fourth code is decoded like the signed 64/64 request.
    localparam logic [TYPE_W-1:0] REQ_U64_BY_U32 = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_U64_BY_U64 = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_S64_BY_S64 = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_S64_ALIAS  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request on an input transfer
        logic prep;     // take magnitudes, detect a zero divisor
        logic step;     // one restoring iteration
        logic out_load; // write the signed-fixed result to the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_step; // the iteration under way produces the final quotient bit
    } status_t;

endpackage

// ===== hdl/idiv64_req_if.sv =====
// Request channel of the 64-bit integer divider: valid/ready plus payload.
// Depends on idiv64_pkg.
`timescale 1ns / 1ps

interface idiv64_req_if;

    logic                             valid;
    logic                             ready;
    logic [idiv64_pkg::TYPE_W-1:0]    req_type;
    logic [idiv64_pkg::DATA_W-1:0]    dividend;
    logic [idiv64_pkg::DATA_W-1:0]    divisor;

    modport source (
        output valid, req_type, dividend, divisor,
        input  ready
    );

    modport sink (
        input  valid, req_type, dividend, divisor,
        output ready
    );

endinterface

// ===== hdl/idiv64_rsp_if.sv =====
// Result channel of the 64-bit integer divider: valid/ready plus payload.
// Depends on idiv64_pkg.
`timescale 1ns / 1ps

interface idiv64_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [idiv64_pkg::DATA_W-1:0]    quotient;
    logic [idiv64_pkg::REM_W-1:0]     remainder;
    logic                             div_by_zero;

    modport source (
        output valid, quotient, remainder, div_by_zero,
        input  ready
    );

    modport sink (
        input  valid, quotient, remainder, div_by_zero,
        output ready
    );

endinterface

// ===== hdl/idiv64_ctrl.sv =====
// Controller of the 64-bit integer divider: sequences load, setup, the
// iterations and the result write, and owns the output valid flag.
// Depends on idiv64_pkg.
`timescale 1ns / 1ps

module idiv64_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  idiv64_pkg::status_t status,
    output idiv64_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIX  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The output register can take a new result when it is empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.prep     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/idiv64_datapath.sv =====
// Datapath of the 64-bit integer divider: operand registers, the restoring
// subtract-and-shift unit, the iteration counter, sign fixing and output register.
// Depends on idiv64_pkg.
`timescale 1ns / 1ps

module idiv64_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  idiv64_pkg::cmd_t                  cmd,
    output idiv64_pkg::status_t               status,
    input  logic [idiv64_pkg::TYPE_W-1:0]     req_type,
    input  logic [idiv64_pkg::DATA_W-1:0]     dividend,
    input  logic [idiv64_pkg::DATA_W-1:0]     divisor,
    output logic [idiv64_pkg::DATA_W-1:0]     quotient,
    output logic [idiv64_pkg::REM_W-1:0]      remainder,
    output logic                              div_by_zero
);

    localparam int unsigned W = idiv64_pkg::DATA_W;
    localparam int unsigned R = idiv64_pkg::REM_W;
    localparam int unsigned C = idiv64_pkg::CNT_W;

    logic [idiv64_pkg::TYPE_W-1:0] mode_reg;
    logic [W-1:0]                  a_reg;     // dividend, then quotient bits shift in
    logic [W-1:0]                  a_next;
    logic [W-1:0]                  d_reg;
    logic [W-1:0]                  d_next;
    logic [W-1:0]                  rem_reg;
    logic [W-1:0]                  rem_next;
    logic                          neg_q_reg;
    logic                          neg_q_next;
    logic                          dz_reg;
    logic                          dz_next;
    logic [C-1:0]                  cnt_reg;
    logic [C-1:0]                  cnt_next;

    logic [W-1:0]                  q_out_reg;
    logic [R-1:0]                  r_out_reg;
    logic                          dz_out_reg;

    logic                          is_signed;
    logic                          neg_a;
    logic                          neg_b;
    logic [W:0]                    shifted;
    logic [W+1:0]                  trial;
    logic [W-1:0]                  q_fixed;
    logic [R-1:0]                  r_fixed;

    always_comb
    begin
        is_signed = mode_reg inside {idiv64_pkg::REQ_S64_BY_S64, idiv64_pkg::REQ_S64_ALIAS};
        neg_a     = is_signed && a_reg[W-1];
        neg_b     = is_signed && d_reg[W-1];
        shifted   = {rem_reg, a_reg[W-1]};
        trial     = {1'b0, shifted} - {2'b00, d_reg};
        q_fixed   = dz_reg ? '0 : (neg_q_reg ? (~a_reg + 1'b1) : a_reg);
        r_fixed   = (!dz_reg && (mode_reg == idiv64_pkg::REQ_U64_BY_U32)) ? rem_reg[R-1:0] : '0;
    end

    always_comb
    begin
        a_next     = a_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        neg_q_next = neg_q_reg;
        dz_next    = dz_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            a_next = dividend;
            if (req_type == idiv64_pkg::REQ_U64_BY_U32)
            begin
                d_next = {{(W-R){1'b0}}, divisor[R-1:0]};
            end
            else
            begin
                d_next = divisor;
            end
        end
        else if (cmd.prep)
        begin
            a_next     = neg_a ? (~a_reg + 1'b1) : a_reg;
            d_next     = neg_b ? (~d_reg + 1'b1) : d_reg;
            neg_q_next = neg_a ^ neg_b;
            dz_next    = (d_reg == '0);
            rem_next   = '0;
            cnt_next   = '0;
        end
        else if (cmd.step)
        begin
            // A partial remainder below the divisor always fits in W bits.
            if (!trial[W+1])
            begin
                rem_next = trial[W-1:0];
                a_next   = {a_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                a_next   = {a_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= req_type;
        end
        a_reg     <= a_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        neg_q_reg <= neg_q_next;
        dz_reg    <= dz_next;
        if (cmd.out_load)
        begin
            q_out_reg  <= q_fixed;
            r_out_reg  <= r_fixed;
            dz_out_reg <= dz_reg;
        end
    end

    assign status.last_step = (cnt_reg == C'(W - 1));
    assign quotient         = q_out_reg;
    assign remainder        = r_out_reg;
    assign div_by_zero      = dz_out_reg;

endmodule

// ===== hdl/integer_divider_64_unit.sv =====
// 64-bit integer divider: unsigned 64/32 with remainder, unsigned 64/64, signed 64/64.
// After the request transfer the block runs one setup step, 64 restoring iterations of the
// shared subtract-and-shift unit and one fixup step that writes the result register.
// A new request is taken only in the idle state, once the previous result has entered
// the output register, so requests are not overlapped.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and empties the result.
`timescale 1ns / 1ps

module integer_divider_64_unit (
    input  logic         clk,
    input  logic         rst_n,
    idiv64_req_if.sink   req,
    idiv64_rsp_if.source rsp
);

    // The controller and the datapath talk only through these two structs.
    idiv64_pkg::cmd_t    cmd;
    idiv64_pkg::status_t status;

    // The controller decides when a request transfer may happen (idle state only)
    // and when the finished result may enter the output register. A result that
    // waits there does not hold up the next request: the output register separates
    // the two channels, and a new result waits in the fixup state until the
    // previous one has been transferred.
    idiv64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath takes magnitudes of signed operands in the setup cycle, runs
    // the restoring division on them and applies the quotient sign at the end.
    // A zero divisor still runs through the iterations; its result is forced to
    // zero with the flag raised. In the 64/32 request only the low 32 divisor
    // bits count, both for the division and for the zero check.
    idiv64_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req.req_type),
        .dividend    (req.dividend),
        .divisor     (req.divisor),
        .quotient    (rsp.quotient),
        .remainder   (rsp.remainder),
        .div_by_zero (rsp.div_by_zero)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for integer_divider_64_unit: a scoreboard class that predicts
// every division, a task that drives the request channel and a process that drives the result channel.
// Depends on idiv64_pkg, idiv64_req_if, idiv64_rsp_if and the divider RTL.
`timescale 1ns / 1ps

// One predicted division outcome, tagged with the request code that caused it.
typedef struct {
    logic [idiv64_pkg::TYPE_W-1:0] kind;
    logic [idiv64_pkg::DATA_W-1:0] quotient;
    logic [idiv64_pkg::REM_W-1:0]  remainder;
    logic                          div_by_zero;
} div_outcome_t;

class divider_scoreboard;
    div_outcome_t awaited[$];
    int unsigned  requests_noted;
    int unsigned  results_checked;
    int unsigned  mismatches;
    int unsigned  zero_divisors;
    int unsigned  per_kind[4];

    // Computes what the divider must return for one request.
    function div_outcome_t divide(input logic [1:0] kind, input logic [63:0] num,
                                  input logic [63:0] den);
        div_outcome_t res;
        logic [63:0]  den32;
        logic [63:0]  mag_num;
        logic [63:0]  mag_den;
        logic [63:0]  mag_quo;
        res.kind        = kind;
        res.quotient    = '0;
        res.remainder   = '0;
        res.div_by_zero = 1'b0;
        case (kind)
            idiv64_pkg::REQ_U64_BY_U32:
            begin
                den32 = {32'd0, den[31:0]};
                if (den32 == 64'd0)
                begin
                    res.div_by_zero = 1'b1;
                end
                else
                begin
                    res.quotient  = num / den32;
                    res.remainder = 32'(num % den32);
                end
            end
            idiv64_pkg::REQ_U64_BY_U64:
            begin
                if (den == 64'd0)
                    res.div_by_zero = 1'b1;
                else
                    res.quotient = num / den;
            end
            default:
            begin
                // Signed codes: divide magnitudes, then restore the sign.
                if (den == 64'd0)
                begin
                    res.div_by_zero = 1'b1;
                end
                else
                begin
                    mag_num = num[63] ? (~num) + 64'd1 : num;
                    mag_den = den[63] ? (~den) + 64'd1 : den;
                    mag_quo = mag_num / mag_den;
                    res.quotient = (num[63] ^ den[63]) ? (~mag_quo) + 64'd1 : mag_quo;
                end
            end
        endcase
        return res;
    endfunction

    function void note_request(input logic [1:0] kind, input logic [63:0] num,
                               input logic [63:0] den);
        awaited.push_back(divide(kind, num, den));
        requests_noted++;
    endfunction

    function void check_result(input logic [63:0] quotient, input logic [31:0] remainder,
                               input logic div_by_zero);
        div_outcome_t exp;
        if (awaited.size() == 0)
        begin
            $error("result transfer with no request outstanding: quotient %h", quotient);
            mismatches++;
            return;
        end
        exp = awaited.pop_front();
        results_checked++;
        per_kind[exp.kind]++;
        if (exp.div_by_zero)
            zero_divisors++;
        if (quotient !== exp.quotient)
        begin
            $error("quotient mismatch: expected %h, got %h", exp.quotient, quotient);
            mismatches++;
        end
        if (remainder !== exp.remainder)
        begin
            $error("remainder mismatch: expected %h, got %h", exp.remainder, remainder);
            mismatches++;
        end
        if (div_by_zero !== exp.div_by_zero)
        begin
            $error("div_by_zero mismatch: expected %b, got %b", exp.div_by_zero, div_by_zero);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int unsigned RANDOM_ITEMS = 400;

    // Length of the drain wait at the end, in clock cycles.
    localparam int unsigned DRAIN_CYCLES = 80;

    // Length of the deliberate result back-pressure window, in clock cycles.
    localparam int unsigned HOLD_CYCLES = 500;

    logic clk;
    logic rst_n;

    idiv64_req_if req_ch ();
    idiv64_rsp_if rsp_ch ();

    integer_divider_64_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    divider_scoreboard results_book = new();

    // Set by the pressure process; while high the receiver refuses every result.
    logic rsp_hold = 1'b0;

    // Number of upcoming requests that the sender offers back to back.
    int unsigned calm_items_left = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Sender idle time before the next request. Most requests follow at once or after a
    // short gap, some gaps are long enough to land within a division in progress so that
    // the offer arrives at varying phases, and a few are long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_items_left > 0)
        begin
            calm_items_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 6)
            calm_items_left = $urandom_range(6, 12);
        if (roll < 45)
            return 0;
        if (roll < 75)
            return $urandom_range(1, 4);
        if (roll < 95)
            return $urandom_range(5, 90);
        return $urandom_range(100, 250);
    endfunction

    // Operand shapes that reach every bit as well as the small, power-of-two
    // and near-all-ones values where division corner cases sit.
    function automatic logic [63:0] shaped_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v;
            1: v = v >> $urandom_range(1, 63);
            2: v = 64'($urandom_range(0, 300));
            3: v = 64'd1 << $urandom_range(0, 63);
            4: v = ~(v >> $urandom_range(1, 63));
            default: v = (~64'($urandom_range(1, 300))) + 64'd1;
        endcase
        return v;
    endfunction

    // Offers one request, waits for its transfer and records the prediction.
    // Entered and left at a falling edge, so valid is assigned at most once
    // per time step.
    task automatic send_division(input logic [1:0] kind, input logic [63:0] num,
                                 input logic [63:0] den);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.dividend <= num;
        req_ch.divisor  <= den;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        results_book.note_request(kind, num, den);
        @(negedge clk);
    endtask

    // Result receiver. Ready runs and stall runs follow in random order with random lengths:
    // mostly short stalls, a few long ones, and occasional long stretches in
    // which every result is taken at once.
    initial
    begin : result_receiver
        int unsigned run_left;
        int unsigned roll;
        logic        level;
        run_left     = 0;
        level        = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(200, 600);
                end
                else if (roll < 55)
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 30);
                end
                else if (roll < 93)
                begin
                    level    = 1'b0;
                    run_left = $urandom_range(1, 4);
                end
                else
                begin
                    level    = 1'b0;
                    run_left = $urandom_range(20, 120);
                end
            end
            rsp_ch.ready <= rsp_hold ? 1'b0 : level;
            run_left--;
        end
    end

    // Back-pressure episode: once the random traffic is under way, results are
    // refused for a long window while the sender keeps offering requests. The
    // result register fills, the datapath finishes the next division and the
    // request channel has to stall.
    initial
    begin : result_pressure
        wait (rst_n === 1'b1);
        while (results_book.requests_noted < 40)
            @(posedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // Result monitor: every result transfer is compared with the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            results_book.check_result(rsp_ch.quotient, rsp_ch.remainder,
                                      rsp_ch.div_by_zero);
    end

    // Watchdog. The slowest correct run is set by roughly 430 requests, each with a full
    // division, the longest sender gap and the longest receiver stall, plus the hold
    // window; the limit allows several times that.
    initial
    begin : watchdog
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [1:0]  kind;
        logic [63:0] num;
        logic [63:0] den;
        int unsigned roll;

        // Every input is known from time zero; reset is asserted from the start and
        // released at a falling edge.
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = idiv64_pkg::REQ_U64_BY_U32;
        req_ch.dividend = '0;
        req_ch.divisor  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Unsigned 64/32: extremes, a zero divisor, a divisor
        // whose low half alone is zero, ignored upper divisor bits, a zero
        // dividend and a dividend smaller than the divisor.
        send_division(idiv64_pkg::REQ_U64_BY_U32, '1, 64'd1);
        send_division(idiv64_pkg::REQ_U64_BY_U32, '1, 64'h0000_0000_FFFF_FFFF);
        send_division(idiv64_pkg::REQ_U64_BY_U32, 64'h1234_5678_9ABC_DEF0,
                      64'hFFFF_FFFF_0000_0000);
        send_division(idiv64_pkg::REQ_U64_BY_U32, '1, 64'd0);
        send_division(idiv64_pkg::REQ_U64_BY_U32, 64'd12345, 64'hDEAD_BEEF_0000_0007);
        send_division(idiv64_pkg::REQ_U64_BY_U32, 64'd0, 64'd5);
        send_division(idiv64_pkg::REQ_U64_BY_U32, 64'd5, 64'd7);

        // Unsigned 64/64: extremes, a zero divisor and full-width divisors.
        send_division(idiv64_pkg::REQ_U64_BY_U64, '1, '1);
        send_division(idiv64_pkg::REQ_U64_BY_U64, '1, 64'd1);
        send_division(idiv64_pkg::REQ_U64_BY_U64, 64'h0123_4567_89AB_CDEF, 64'd0);
        send_division(idiv64_pkg::REQ_U64_BY_U64, 64'h8000_0000_0000_0000,
                      64'h8000_0000_0000_0001);
        send_division(idiv64_pkg::REQ_U64_BY_U64, '1, 64'h0000_0001_0000_0000);

        // Signed 64/64: the most negative dividend by minus one and by one,
        // every sign combination with a negative operand, a zero divisor and the most negative divisor.
        send_division(idiv64_pkg::REQ_S64_BY_S64, 64'h8000_0000_0000_0000, '1);
        send_division(idiv64_pkg::REQ_S64_BY_S64, 64'h8000_0000_0000_0000, 64'd1);
        send_division(idiv64_pkg::REQ_S64_BY_S64, -64'sd7, 64'd2);
        send_division(idiv64_pkg::REQ_S64_BY_S64, 64'd7, -64'sd2);
        send_division(idiv64_pkg::REQ_S64_BY_S64, -64'sd7, -64'sd2);
        send_division(idiv64_pkg::REQ_S64_BY_S64, -64'sd7, 64'd0);
        send_division(idiv64_pkg::REQ_S64_BY_S64, 64'h7FFF_FFFF_FFFF_FFFF,
                      64'h8000_0000_0000_0000);
        send_division(idiv64_pkg::REQ_S64_BY_S64, 64'h8000_0000_0000_0000,
                      64'h8000_0000_0000_0000);

        // The spare request code must behave like the signed one.
        send_division(idiv64_pkg::REQ_S64_ALIAS, 64'h8000_0000_0000_0000, '1);
        send_division(idiv64_pkg::REQ_S64_ALIAS, -64'sd100, 64'd7);
        send_division(idiv64_pkg::REQ_S64_ALIAS, 64'd42, 64'd0);

        // Random part: all four request codes, shaped operands and about one
        // zero divisor in twenty.
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            roll = $urandom_range(0, 15);
            if (roll < 5)
                kind = idiv64_pkg::REQ_U64_BY_U32;
            else if (roll < 10)
                kind = idiv64_pkg::REQ_U64_BY_U64;
            else if (roll < 14)
                kind = idiv64_pkg::REQ_S64_BY_S64;
            else
                kind = idiv64_pkg::REQ_S64_ALIAS;
            num = shaped_value();
            den = shaped_value();
            if ($urandom_range(0, 19) == 0)
            begin
                if (kind == idiv64_pkg::REQ_U64_BY_U32)
                    den[31:0] = '0;
                else
                    den = '0;
            end
            send_division(kind, num, den);
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every outstanding result, then a little longer so a
        // stray extra transfer would still be seen.
        while (results_book.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d divisions: %0d u64/u32, %0d u64/u64, %0d signed, %0d spare code.",
                 results_book.results_checked,
                 results_book.per_kind[idiv64_pkg::REQ_U64_BY_U32],
                 results_book.per_kind[idiv64_pkg::REQ_U64_BY_U64],
                 results_book.per_kind[idiv64_pkg::REQ_S64_BY_S64],
                 results_book.per_kind[idiv64_pkg::REQ_S64_ALIAS]);
        $display("%0d zero divisors, random idling on both channels and one %0d-cycle hold.",
                 results_book.zero_divisors, HOLD_CYCLES);
        if (results_book.mismatches == 0 && results_book.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
